// ----- rtl/pcr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared constants, register indexes and rounding helper for the pose
// consensus residual unit.
// ----------------------------------------------------------------------------
package pcr_pkg;

    localparam int VEC_W     = 21;
    localparam int QUAT_W    = 16;
    localparam int DIFF_W    = 22;
    localparam int PROD_W    = 32;
    localparam int MAT_W     = 34;
    localparam int MPROD_W   = 56;
    localparam int POS_W     = 37;
    localparam int ROT_W     = 29;
    localparam int ENT_W     = 23;
    localparam int WGT_W     = 32;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int NUM_W     = 22;
    localparam int PIPE_D    = 6;

    localparam logic [MAT_W-1:0] ONE_Q28 = MAT_W'(64'd1 << 28);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_POS   = 3'd0,
        CFG_REF_ROT   = 3'd1,
        CFG_POS_OFF   = 3'd2,
        CFG_ANG_OFF   = 3'd3,
        CFG_ROT_WGT   = 3'd4,
        CFG_TRN_WGT   = 3'd5
    } t_cfg_idx;

    localparam logic [2:0] BEAT_RES  = 3'd0;
    localparam logic [2:0] BEAT_LAST = 3'd6;

    localparam int W_POS = 0;
    localparam int W_ROT = 3;
    localparam int W_RM  = 6;
    localparam int W_EW  = 15;
    localparam int W_EV  = 16;
    localparam int W_NEV = 19;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input int unsigned s);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ----- rtl/pcr_wmul.sv -----
// ----------------------------------------------------------------------------
// pcr_wmul
// Two-stage Q.16 by unsigned Q16.16 weight multiply, rounded and saturated.
// ----------------------------------------------------------------------------
module pcr_wmul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [pcr_pkg::POS_W-1:0]    i_x,
    input  logic        [pcr_pkg::WGT_W-1:0]    i_w,
    output logic signed [pcr_pkg::OUT_W-1:0]    o_y
);
    logic [pcr_pkg::POS_W-1:0] mag;
    logic                      r_neg;
    logic [52:0]               r_hi;
    logic [48:0]               r_lo;
    logic [53:0]               res;
    logic signed [pcr_pkg::OUT_W-1:0] n_y;
    logic signed [pcr_pkg::OUT_W-1:0] r_y;

    function automatic logic signed [pcr_pkg::OUT_W-1:0] OUT_W_neg(input logic [53:0] r);
        logic [31:0] t;
        t = r[31:0];
        return $signed(32'(-t));
    endfunction

    assign mag = i_x[pcr_pkg::POS_W-1] ? pcr_pkg::POS_W'(-i_x) : pcr_pkg::POS_W'(i_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_x[pcr_pkg::POS_W-1];
            r_hi  <= 53'(mag[pcr_pkg::POS_W-1:16]) * 53'(i_w);
            r_lo  <= 49'(mag[15:0]) * 49'(i_w) + 49'h8000;
            r_y   <= n_y;
        end
    end

    assign res = 54'(r_hi) + 54'(r_lo >> 16);

    always_comb begin
        if (r_neg) begin
            n_y = (res > 54'h80000000) ? 32'sh80000000 : OUT_W_neg(res);
        end else begin
            n_y = (res > 54'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(res[31:0]);
        end
    end

    assign o_y = r_y;
endmodule

// ----- rtl/pose_consensus_residual_unit.sv -----
// ----------------------------------------------------------------------------
// pose_consensus_residual_unit
// Weighted SE(3) pose residual with optional 6x7 Jacobian rows.
// ----------------------------------------------------------------------------
// An input beat is taken every cycle the result side keeps up; each item
// passes through six pipeline stages and one output holding register, the
// first stage loaded at the accepting edge. An item without Jacobian leaves
// as one result beat, an item with Jacobian as seven beats, and the single
// result channel takes no new input until the last of those beats is taken.
// The user must write configuration only while no item is in flight; the
// block itself does not enforce it.
module pose_consensus_residual_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pcr_pkg::CFG_DAT_W-1:0]          i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [pcr_pkg::VEC_W-1:0]       i_pos_x,
    input  logic signed [pcr_pkg::VEC_W-1:0]       i_pos_y,
    input  logic signed [pcr_pkg::VEC_W-1:0]       i_pos_z,
    input  logic signed [pcr_pkg::QUAT_W-1:0]      i_quat_x,
    input  logic signed [pcr_pkg::QUAT_W-1:0]      i_quat_y,
    input  logic signed [pcr_pkg::QUAT_W-1:0]      i_quat_z,
    input  logic signed [pcr_pkg::QUAT_W-1:0]      i_quat_w,
    input  logic                                   i_want_jacobian,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_kind,
    output logic [2:0]                             o_row,
    output logic signed [pcr_pkg::OUT_W-1:0]       o_v0,
    output logic signed [pcr_pkg::OUT_W-1:0]       o_v1,
    output logic signed [pcr_pkg::OUT_W-1:0]       o_v2,
    output logic signed [pcr_pkg::OUT_W-1:0]       o_v3,
    output logic signed [pcr_pkg::OUT_W-1:0]       o_v4,
    output logic signed [pcr_pkg::OUT_W-1:0]       o_v5,
    output logic signed [pcr_pkg::OUT_W-1:0]       o_v6,
    output logic                                   o_last
);
    // configuration
    logic [62:0] r_ref_pos, r_pos_off, r_ang_off;
    logic [63:0] r_ref_rot;
    logic [pcr_pkg::WGT_W-1:0] r_rot_wgt, r_trn_wgt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_pos <= '0;
            r_ref_rot <= 64'd16384;
            r_pos_off <= '0;
            r_ang_off <= '0;
            r_rot_wgt <= 32'd65536;
            r_trn_wgt <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcr_pkg::CFG_REF_POS: r_ref_pos <= i_cfg_data[62:0];
                pcr_pkg::CFG_REF_ROT: r_ref_rot <= i_cfg_data;
                pcr_pkg::CFG_POS_OFF: r_pos_off <= i_cfg_data[62:0];
                pcr_pkg::CFG_ANG_OFF: r_ang_off <= i_cfg_data[62:0];
                pcr_pkg::CFG_ROT_WGT: r_rot_wgt <= i_cfg_data[31:0];
                pcr_pkg::CFG_TRN_WGT: r_trn_wgt <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [pcr_pkg::QUAT_W-1:0] rw, rx, ry, rz;
    assign rw = $signed(r_ref_rot[63:48]);
    assign rz = $signed(r_ref_rot[47:32]);
    assign ry = $signed(r_ref_rot[31:16]);
    assign rx = $signed(r_ref_rot[15:0]);

    // pipeline control
    logic                       en;
    logic                       r_full;
    logic                       r_hjac;
    logic [2:0]                 r_beat;
    logic                       last_beat;
    logic [pcr_pkg::PIPE_D-1:0] r_vld;
    logic [pcr_pkg::PIPE_D-1:0] r_jac;

    assign last_beat = !r_hjac || (r_beat == pcr_pkg::BEAT_LAST);
    assign en        = !r_full || (i_ready && last_beat);
    assign o_ready   = en;
    assign o_valid   = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_full <= 1'b0;
            r_beat <= pcr_pkg::BEAT_RES;
        end else if (en) begin
            r_vld  <= {r_vld[pcr_pkg::PIPE_D-2:0], i_valid};
            r_full <= r_vld[pcr_pkg::PIPE_D-1];
            r_beat <= pcr_pkg::BEAT_RES;
        end else if (i_ready) begin
            r_beat <= r_beat + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_jac  <= {r_jac[pcr_pkg::PIPE_D-2:0], i_want_jacobian};
            r_hjac <= r_jac[pcr_pkg::PIPE_D-1];
        end
    end

    function automatic logic signed [pcr_pkg::DIFF_W-1:0] DIFF_W_sub(
        input logic signed [pcr_pkg::VEC_W-1:0] a,
        input logic signed [pcr_pkg::VEC_W-1:0] b);
        return pcr_pkg::DIFF_W'(a) - pcr_pkg::DIFF_W'(b);
    endfunction

    function automatic logic signed [pcr_pkg::MAT_W-1:0] m34(
        input logic signed [pcr_pkg::PROD_W-1:0] p);
        return pcr_pkg::MAT_W'(p);
    endfunction

    // stage 1: differences and products
    logic signed [pcr_pkg::DIFF_W-1:0] r1_d [3];
    logic signed [pcr_pkg::PROD_W-1:0] r1_ww, r1_xx, r1_yy, r1_zz;
    logic signed [pcr_pkg::PROD_W-1:0] r1_wlx, r1_lwx, r1_ylz, r1_zly;
    logic signed [pcr_pkg::PROD_W-1:0] r1_wly, r1_lwy, r1_zlx, r1_xlz;
    logic signed [pcr_pkg::PROD_W-1:0] r1_wlz, r1_lwz, r1_xly, r1_ylx;
    logic signed [pcr_pkg::PROD_W-1:0] r1_pxx, r1_pyy, r1_pzz, r1_pxy, r1_pwz;
    logic signed [pcr_pkg::PROD_W-1:0] r1_pxz, r1_pwy, r1_pyz, r1_pwx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0] <= DIFF_W_sub(i_pos_x, $signed(r_ref_pos[20:0]));
            r1_d[1] <= DIFF_W_sub(i_pos_y, $signed(r_ref_pos[41:21]));
            r1_d[2] <= DIFF_W_sub(i_pos_z, $signed(r_ref_pos[62:42]));
            r1_ww  <= 32'(rw) * 32'(i_quat_w);
            r1_xx  <= 32'(rx) * 32'(i_quat_x);
            r1_yy  <= 32'(ry) * 32'(i_quat_y);
            r1_zz  <= 32'(rz) * 32'(i_quat_z);
            r1_wlx <= 32'(rw) * 32'(i_quat_x);
            r1_lwx <= 32'(i_quat_w) * 32'(rx);
            r1_ylz <= 32'(ry) * 32'(i_quat_z);
            r1_zly <= 32'(rz) * 32'(i_quat_y);
            r1_wly <= 32'(rw) * 32'(i_quat_y);
            r1_lwy <= 32'(i_quat_w) * 32'(ry);
            r1_zlx <= 32'(rz) * 32'(i_quat_x);
            r1_xlz <= 32'(rx) * 32'(i_quat_z);
            r1_wlz <= 32'(rw) * 32'(i_quat_z);
            r1_lwz <= 32'(i_quat_w) * 32'(rz);
            r1_xly <= 32'(rx) * 32'(i_quat_y);
            r1_ylx <= 32'(ry) * 32'(i_quat_x);
            r1_pxx <= 32'(rx) * 32'(rx);
            r1_pyy <= 32'(ry) * 32'(ry);
            r1_pzz <= 32'(rz) * 32'(rz);
            r1_pxy <= 32'(rx) * 32'(ry);
            r1_pwz <= 32'(rw) * 32'(rz);
            r1_pxz <= 32'(rx) * 32'(rz);
            r1_pwy <= 32'(rw) * 32'(ry);
            r1_pyz <= 32'(ry) * 32'(rz);
            r1_pwx <= 32'(rw) * 32'(rx);
        end
    end

    // stage 2: rotation matrix and error quaternion, Q.28
    logic signed [pcr_pkg::MAT_W-1:0]  r2_r [3][3];
    logic signed [pcr_pkg::MAT_W-1:0]  r2_ev [3];
    logic signed [pcr_pkg::MAT_W-1:0]  r2_ew;
    logic signed [pcr_pkg::DIFF_W-1:0] r2_d [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_d    <= r1_d;
            r2_r[0][0] <= $signed(pcr_pkg::ONE_Q28) - 2 * (m34(r1_pyy) + m34(r1_pzz));
            r2_r[0][1] <= 2 * (m34(r1_pxy) - m34(r1_pwz));
            r2_r[0][2] <= 2 * (m34(r1_pxz) + m34(r1_pwy));
            r2_r[1][0] <= 2 * (m34(r1_pxy) + m34(r1_pwz));
            r2_r[1][1] <= $signed(pcr_pkg::ONE_Q28) - 2 * (m34(r1_pxx) + m34(r1_pzz));
            r2_r[1][2] <= 2 * (m34(r1_pyz) - m34(r1_pwx));
            r2_r[2][0] <= 2 * (m34(r1_pxz) - m34(r1_pwy));
            r2_r[2][1] <= 2 * (m34(r1_pyz) + m34(r1_pwx));
            r2_r[2][2] <= $signed(pcr_pkg::ONE_Q28) - 2 * (m34(r1_pxx) + m34(r1_pyy));
            r2_ew    <= m34(r1_ww) + m34(r1_xx) + m34(r1_yy) + m34(r1_zz);
            r2_ev[0] <= m34(r1_wlx) - m34(r1_lwx) - m34(r1_ylz) + m34(r1_zly);
            r2_ev[1] <= m34(r1_wly) - m34(r1_lwy) - m34(r1_zlx) + m34(r1_xlz);
            r2_ev[2] <= m34(r1_wlz) - m34(r1_lwz) - m34(r1_xly) + m34(r1_ylx);
        end
    end

    // stage 3: matrix-vector products and Q.16 rounding
    logic signed [pcr_pkg::MPROD_W-1:0] r3_pr [3][3];
    logic signed [pcr_pkg::ROT_W-1:0]   r3_rot [3];
    logic signed [pcr_pkg::ENT_W-1:0]   r3_rm [3][3];
    logic signed [pcr_pkg::ENT_W-1:0]   r3_ev [3];
    logic signed [pcr_pkg::ENT_W-1:0]   r3_ew;
    logic signed [63:0]                 rot_sum [3];
    logic signed [63:0]                 ew_rnd;
    logic signed [63:0]                 ev_rnd [3];
    logic signed [63:0]                 rm_rnd [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rot_sum[i] = pcr_pkg::rnd(64'(r2_ev[i]) * 64'sd2
                         + (64'($signed(r_ang_off[21*i +: 21])) <<< 18), 12);
            ev_rnd[i]  = pcr_pkg::rnd(64'(r2_ev[i]), 12);
            for (int j = 0; j < 3; j++) begin
                rm_rnd[i][j] = pcr_pkg::rnd(64'(r2_r[i][j]), 12);
            end
        end
        ew_rnd = pcr_pkg::rnd(64'(r2_ew), 12);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_rot[i] <= rot_sum[i][pcr_pkg::ROT_W-1:0];
                r3_ev[i]  <= ev_rnd[i][pcr_pkg::ENT_W-1:0];
                for (int j = 0; j < 3; j++) begin
                    r3_pr[i][j] <= pcr_pkg::MPROD_W'(r2_r[j][i])
                                   * pcr_pkg::MPROD_W'(r2_d[j]);
                    r3_rm[i][j] <= rm_rnd[i][j][pcr_pkg::ENT_W-1:0];
                end
            end
            r3_ew <= ew_rnd[pcr_pkg::ENT_W-1:0];
        end
    end

    // stage 4: position sum, operands for the weight multipliers
    logic signed [63:0]                pos_sum [3];
    logic signed [pcr_pkg::POS_W-1:0]  r4_x [pcr_pkg::NUM_W];
    logic        [pcr_pkg::WGT_W-1:0]  wgt  [pcr_pkg::NUM_W];
    logic signed [pcr_pkg::OUT_W-1:0]  wy   [pcr_pkg::NUM_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_sum[i] = pcr_pkg::rnd((64'($signed(r_pos_off[21*i +: 21])) <<< 28)
                         + 64'(r3_pr[i][0]) + 64'(r3_pr[i][1]) + 64'(r3_pr[i][2]), 22);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r4_x[pcr_pkg::W_POS + i] <= pos_sum[i][pcr_pkg::POS_W-1:0];
                r4_x[pcr_pkg::W_ROT + i] <= pcr_pkg::POS_W'(r3_rot[i]);
                r4_x[pcr_pkg::W_EV + i]  <= pcr_pkg::POS_W'(r3_ev[i]);
                r4_x[pcr_pkg::W_NEV + i] <= -pcr_pkg::POS_W'(r3_ev[i]);
                for (int j = 0; j < 3; j++) begin
                    r4_x[pcr_pkg::W_RM + 3*i + j] <= pcr_pkg::POS_W'(r3_rm[i][j]);
                end
            end
            r4_x[pcr_pkg::W_EW] <= pcr_pkg::POS_W'(r3_ew);
        end
    end

    // stages 5 and 6: weight multipliers
    always_comb begin
        for (int k = 0; k < pcr_pkg::NUM_W; k++) begin
            if (k < pcr_pkg::W_ROT || (k >= pcr_pkg::W_RM && k < pcr_pkg::W_EW)) begin
                wgt[k] = r_trn_wgt;
            end else begin
                wgt[k] = r_rot_wgt;
            end
        end
    end

    for (genvar k = 0; k < pcr_pkg::NUM_W; k++) begin : g_wmul
        pcr_wmul u_wmul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (r4_x[k]),
            .i_w   (wgt[k]),
            .o_y   (wy[k])
        );
    end

    // output holding register
    logic signed [pcr_pkg::OUT_W-1:0] r_res [pcr_pkg::NUM_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= wy;
        end
    end

    always_comb begin
        o_kind = (r_beat != pcr_pkg::BEAT_RES);
        o_row  = (r_beat == pcr_pkg::BEAT_RES) ? 3'd0 : r_beat - 3'd1;
        o_last = last_beat;
        o_v0 = '0; o_v1 = '0; o_v2 = '0;
        o_v3 = '0; o_v4 = '0; o_v5 = '0; o_v6 = '0;
        case (r_beat)
            3'd0: begin
                o_v0 = r_res[pcr_pkg::W_POS];
                o_v1 = r_res[pcr_pkg::W_POS + 1];
                o_v2 = r_res[pcr_pkg::W_POS + 2];
                o_v3 = r_res[pcr_pkg::W_ROT];
                o_v4 = r_res[pcr_pkg::W_ROT + 1];
                o_v5 = r_res[pcr_pkg::W_ROT + 2];
            end
            3'd1: begin
                o_v0 = r_res[pcr_pkg::W_RM];
                o_v1 = r_res[pcr_pkg::W_RM + 3];
                o_v2 = r_res[pcr_pkg::W_RM + 6];
            end
            3'd2: begin
                o_v0 = r_res[pcr_pkg::W_RM + 1];
                o_v1 = r_res[pcr_pkg::W_RM + 4];
                o_v2 = r_res[pcr_pkg::W_RM + 7];
            end
            3'd3: begin
                o_v0 = r_res[pcr_pkg::W_RM + 2];
                o_v1 = r_res[pcr_pkg::W_RM + 5];
                o_v2 = r_res[pcr_pkg::W_RM + 8];
            end
            3'd4: begin
                o_v3 = r_res[pcr_pkg::W_EW];
                o_v4 = r_res[pcr_pkg::W_NEV + 2];
                o_v5 = r_res[pcr_pkg::W_EV + 1];
            end
            3'd5: begin
                o_v3 = r_res[pcr_pkg::W_EV + 2];
                o_v4 = r_res[pcr_pkg::W_EW];
                o_v5 = r_res[pcr_pkg::W_NEV];
            end
            3'd6: begin
                o_v3 = r_res[pcr_pkg::W_NEV + 1];
                o_v4 = r_res[pcr_pkg::W_EV];
                o_v5 = r_res[pcr_pkg::W_EW];
            end
            default: ;
        endcase
    end
endmodule

// ----- bench/tb_pose_consensus_residual_unit.sv -----
// ----------------------------------------------------------------------------
// tb_pose_consensus_residual_unit
// Drives local poses through the residual unit under several reference,
// offset and weight settings, predicts every residual and Jacobian row, and
// compares each result beat field by field with randomly stalled handshakes.
// ----------------------------------------------------------------------------
module tb_pose_consensus_residual_unit;

    typedef struct {
        logic        kind;
        logic [2:0]  row;
        logic [31:0] v [7];
        logic        last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [pcr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pcr_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [pcr_pkg::VEC_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [pcr_pkg::QUAT_W-1:0] i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic signed [pcr_pkg::QUAT_W-1:0] i_quat_w = '0;
    logic i_want_jacobian = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_kind, o_last;
    logic [2:0] o_row;
    logic signed [pcr_pkg::OUT_W-1:0] o_v0, o_v1, o_v2, o_v3, o_v4, o_v5, o_v6;

    pose_consensus_residual_unit DUT (.*);

    always #4 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [62:0] m_ref_pos, m_pos_off, m_ang_off;
    logic [63:0] m_ref_rot;
    logic [31:0] m_rot_wgt, m_trn_wgt;

    t_result expected_beats [$];
    int errors = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int hold_off = 0;

    function automatic longint fld(logic [63:0] v, int lsb, int bits);
        logic [63:0] u;
        u = (v >> lsb) & ((64'd1 << bits) - 1);
        if (u[bits-1]) return longint'(u) - (longint'(1) << bits);
        return longint'(u);
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [31:0] weigh(longint x, logic [31:0] w);
        longint unsigned mag, res;
        mag = (x < 0) ? longint'(-x) : x;
        res = (mag >> 16) * w + (((mag & 64'hFFFF) * w + 64'h8000) >> 16);
        if (x < 0) return (res > 64'h80000000) ? 32'h80000000 : 32'(-longint'(res));
        return (res > 64'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(res);
    endfunction

    task automatic predict_pose(logic [20:0] px, logic [20:0] py, logic [20:0] pz,
                                logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                logic [15:0] qw, logic jac);
        longint d [3], rm [3][3], mm [3][3], ev [3];
        longint rx, ry, rz, rw, lx, ly, lz, lw, ew, s;
        t_result r;
        d[0] = fld(px, 0, 21) - fld(m_ref_pos, 0, 21);
        d[1] = fld(py, 0, 21) - fld(m_ref_pos, 21, 21);
        d[2] = fld(pz, 0, 21) - fld(m_ref_pos, 42, 21);
        lx = fld(qx, 0, 16); ly = fld(qy, 0, 16); lz = fld(qz, 0, 16);
        lw = fld(qw, 0, 16);
        rw = fld(m_ref_rot, 48, 16); rz = fld(m_ref_rot, 32, 16);
        ry = fld(m_ref_rot, 16, 16); rx = fld(m_ref_rot, 0, 16);
        rm[0][0] = (longint'(1) << 28) - 2 * (ry * ry + rz * rz);
        rm[0][1] = 2 * (rx * ry - rw * rz);
        rm[0][2] = 2 * (rx * rz + rw * ry);
        rm[1][0] = 2 * (rx * ry + rw * rz);
        rm[1][1] = (longint'(1) << 28) - 2 * (rx * rx + rz * rz);
        rm[1][2] = 2 * (ry * rz - rw * rx);
        rm[2][0] = 2 * (rx * rz - rw * ry);
        rm[2][1] = 2 * (ry * rz + rw * rx);
        rm[2][2] = (longint'(1) << 28) - 2 * (rx * rx + ry * ry);
        ew = rw * lw + (rx * lx + ry * ly + rz * lz);
        ev[0] = rw * lx - lw * rx + (-ry * lz + rz * ly);
        ev[1] = rw * ly - lw * ry + (-rz * lx + rx * lz);
        ev[2] = rw * lz - lw * rz + (-rx * ly + ry * lx);
        r.kind = 1'b0; r.row = pcr_pkg::BEAT_RES; r.last = !jac; r.v[6] = '0;
        for (int i = 0; i < 3; i++) begin
            s = fld(m_pos_off, 21 * i, 21) * (longint'(1) << 28);
            for (int j = 0; j < 3; j++) s += rm[j][i] * d[j];
            r.v[i] = weigh(round_shift(s, 22), m_trn_wgt);
            r.v[3 + i] = weigh(round_shift(2 * ev[i] +
                fld(m_ang_off, 21 * i, 21) * (longint'(1) << 18), 12), m_rot_wgt);
        end
        expected_beats.push_back(r);
        if (!jac) return;
        mm[0][0] = ew;     mm[0][1] = -ev[2]; mm[0][2] = ev[1];
        mm[1][0] = ev[2];  mm[1][1] = ew;     mm[1][2] = -ev[0];
        mm[2][0] = -ev[1]; mm[2][1] = ev[0];  mm[2][2] = ew;
        for (int i = 0; i < 6; i++) begin
            r.kind = 1'b1; r.row = 3'(i); r.last = (i == 5);
            for (int j = 0; j < 7; j++) r.v[j] = '0;
            for (int j = 0; j < 3; j++) begin
                if (i < 3) r.v[j] = weigh(round_shift(rm[j][i], 12), m_trn_wgt);
                else r.v[3 + j] = weigh(round_shift(mm[i - 3][j], 12), m_rot_wgt);
            end
            expected_beats.push_back(r);
        end
    endtask

    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_pose(logic [20:0] px, logic [20:0] py, logic [20:0] pz,
                             logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                             logic [15:0] qw, logic jac);
        idle_gap();
        i_valid <= 1'b1;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz; i_quat_w <= qw;
        i_want_jacobian <= jac;
        do @(posedge i_clk); while (!o_ready);
        predict_pose(px, py, pz, qx, qy, qz, qw, jac);
    endtask

    task automatic write_reg(pcr_pkg::t_cfg_idx idx, logic [63:0] data);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pcr_pkg::CFG_REF_POS: m_ref_pos = data[62:0];
            pcr_pkg::CFG_REF_ROT: m_ref_rot = data;
            pcr_pkg::CFG_POS_OFF: m_pos_off = data[62:0];
            pcr_pkg::CFG_ANG_OFF: m_ang_off = data[62:0];
            pcr_pkg::CFG_ROT_WGT: m_rot_wgt = data[31:0];
            pcr_pkg::CFG_TRN_WGT: m_trn_wgt = data[31:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_q();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [63:0] rand_vec3();
        return {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    task automatic send_random(int n);
        for (int k = 0; k < n; k++)
            send_pose(21'($urandom), 21'($urandom), 21'($urandom), rand_q(),
                      rand_q(), rand_q(), rand_q(), 1'($urandom_range(1)));
    endtask

    task automatic test_reset_defaults();
        send_pose('0, '0, '0, '0, '0, '0, 16'sd16384, 1'b1);
        send_pose(21'h0FFFFF, 21'h100000, 21'h1FFFFF, 16'sd16384, -16'sd16384,
                  16'h7FFF, 16'h8000, 1'b0);
        send_pose(21'h100000, 21'h0FFFFF, 21'h000001, -16'sd16384, 16'sd16384,
                  16'h8000, 16'h7FFF, 1'b1);
        drain();
    endtask

    task automatic test_extreme_config();
        write_reg(pcr_pkg::CFG_REF_POS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(pcr_pkg::CFG_REF_ROT, 64'h8000_7FFF_8000_7FFF);
        write_reg(pcr_pkg::CFG_POS_OFF, 64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(pcr_pkg::CFG_ANG_OFF, 64'h4000_0200_0010_0000);
        write_reg(pcr_pkg::CFG_ROT_WGT, 64'hFFFF_FFFF);
        write_reg(pcr_pkg::CFG_TRN_WGT, 64'hFFFF_FFFF);
        send_pose(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 1'b1);
        send_pose(21'h100000, 21'h100000, 21'h100000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 1'b1);
        drain();
        write_reg(pcr_pkg::CFG_ROT_WGT, 64'h0);
        write_reg(pcr_pkg::CFG_TRN_WGT, 64'h0);
        send_pose(21'h0ABCDE, 21'h012345, 21'h1F0F0F, 16'h1234, 16'h4321,
                  16'hC000, 16'h2000, 1'b1);
        drain();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++) begin
            write_reg(pcr_pkg::CFG_REF_POS, rand_vec3());
            write_reg(pcr_pkg::CFG_REF_ROT, {rand_q(), rand_q(), rand_q(), rand_q()});
            write_reg(pcr_pkg::CFG_POS_OFF, rand_vec3());
            write_reg(pcr_pkg::CFG_ANG_OFF, rand_vec3());
            write_reg(pcr_pkg::CFG_ROT_WGT, (p % 2) ? $urandom : $urandom_range(196608));
            write_reg(pcr_pkg::CFG_TRN_WGT, (p % 3) ? $urandom_range(196608) : $urandom);
            calm = (p == 2);
            send_random(60);
            calm = 1'b0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        send_random(30);
        drain();
    endtask

    initial begin
        write_reg_init: begin
            m_ref_pos = '0; m_ref_rot = 64'd16384; m_pos_off = '0; m_ang_off = '0;
            m_rot_wgt = 32'd65536; m_trn_wgt = 32'd65536;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extreme_config();
        test_random_settings();
        test_backpressure();
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        logic [31:0] got [7];
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_v0, o_v1, o_v2, o_v3, o_v4, o_v5, o_v6};
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind expected %0d got %0d", e.kind, o_kind); errors++;
                end
                if (o_row !== e.row) begin
                    $error("row expected %0d got %0d", e.row, o_row); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d got %0d", e.last, o_last); errors++;
                end
                for (int k = 0; k < 7; k++)
                    if (got[k] !== e.v[k]) begin
                        $error("v%0d expected %h got %h", k, e.v[k], got[k]);
                        errors++;
                    end
            end
        end
    end
endmodule
